[hdl/ldrs_pkg.sv]
package ldrs_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CYL_W   = 16;
    localparam int TOTAL_W = 19;
    localparam int OUT_W   = 56;

    localparam logic [CYL_W-1:0] START_RESET = 16'd53;

    typedef struct packed {
        logic load;
        logic start_batch;
        logic scan;
        logic emit;
    } ldrs_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic pick_last;
        logic out_free;
    } ldrs_status_t;

endpackage

[hdl/ldrs_ctrl.sv]
module ldrs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    input  ldrs_pkg::ldrs_status_t status,
    output ldrs_pkg::ldrs_cmd_t    cmd
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        cmd.load        = 1'b0;
        cmd.start_batch = 1'b0;
        cmd.scan        = 1'b0;
        cmd.emit        = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    if (s_tlast)
                    begin
                        cmd.start_batch = 1'b1;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.pick_last ? ST_LOAD : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

[hdl/ldrs_datapath.sv]
module ldrs_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ldrs_pkg::CYL_W-1:0]    cfg_wr_data,
    input  logic [ldrs_pkg::CYL_W-1:0]    cylinder,
    input  ldrs_pkg::ldrs_cmd_t           cmd,
    output ldrs_pkg::ldrs_status_t        status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ldrs_pkg::OUT_W-1:0]    m_tdata,
    output logic                          m_tlast
);

    logic [ldrs_pkg::CYL_W-1:0]       start_reg;
    logic [ldrs_pkg::CYL_W-1:0]       store_reg [ldrs_pkg::QUEUE_DEPTH];
    logic [ldrs_pkg::CNT_W-1:0]       count_reg;
    logic [ldrs_pkg::CNT_W-1:0]       served_cnt_reg;
    logic [ldrs_pkg::QUEUE_DEPTH-1:0] marks_reg;
    logic [ldrs_pkg::IDX_W-1:0]       scan_idx_reg;
    logic                             found_reg;
    logic                             best_low_reg;
    logic [ldrs_pkg::IDX_W-1:0]       best_idx_reg;
    logic [ldrs_pkg::CYL_W-1:0]       best_val_reg;
    logic [ldrs_pkg::CYL_W-1:0]       head_reg;
    logic [ldrs_pkg::TOTAL_W-1:0]     sum_reg;

    logic                             out_valid_reg;
    logic [ldrs_pkg::CYL_W-1:0]       out_cyl_reg;
    logic [ldrs_pkg::CYL_W-1:0]       out_dist_reg;
    logic [ldrs_pkg::TOTAL_W-1:0]     out_total_reg;
    logic                             out_last_reg;

    logic [ldrs_pkg::CYL_W-1:0]       scan_val;
    logic                             scan_low;
    logic                             better;
    logic [ldrs_pkg::CYL_W-1:0]       seek_dist;
    logic [ldrs_pkg::TOTAL_W-1:0]     sum_next;

    assign scan_val = store_reg[scan_idx_reg];
    assign scan_low = (scan_val <= start_reg);

    // downward sweep first: highest at or below start, then lowest above it
    assign better = !marks_reg[scan_idx_reg]
                    && (!found_reg
                        || (scan_low && !best_low_reg)
                        || (scan_low && best_low_reg && (scan_val > best_val_reg))
                        || (!scan_low && !best_low_reg && (scan_val < best_val_reg)));

    assign seek_dist = (best_val_reg > head_reg) ? (best_val_reg - head_reg)
                                                 : (head_reg - best_val_reg);
    assign sum_next  = sum_reg + {{(ldrs_pkg::TOTAL_W - ldrs_pkg::CYL_W){1'b0}}, seek_dist};

    assign status.scan_last = ({{(ldrs_pkg::CNT_W - ldrs_pkg::IDX_W){1'b0}}, scan_idx_reg}
                               == (count_reg - 1'b1));
    assign status.pick_last = ((served_cnt_reg + 1'b1) == count_reg);
    assign status.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= ldrs_pkg::START_RESET;
            count_reg      <= '0;
            served_cnt_reg <= '0;
            marks_reg      <= '0;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            head_reg       <= ldrs_pkg::START_RESET;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_reg <= cfg_wr_data;
            end
            if (m_tready && !cmd.emit)
            begin
                out_valid_reg <= 1'b0;
            end
            // requests past the queue depth are dropped
            if (cmd.load && (count_reg < ldrs_pkg::CNT_W'(ldrs_pkg::QUEUE_DEPTH)))
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.start_batch)
            begin
                head_reg       <= start_reg;
                sum_reg        <= '0;
                marks_reg      <= '0;
                served_cnt_reg <= '0;
                scan_idx_reg   <= '0;
                found_reg      <= 1'b0;
            end
            if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg           <= 1'b1;
                head_reg                <= best_val_reg;
                sum_reg                 <= sum_next;
                marks_reg[best_idx_reg] <= 1'b1;
                served_cnt_reg          <= served_cnt_reg + 1'b1;
                scan_idx_reg            <= '0;
                found_reg               <= 1'b0;
                if (status.pick_last)
                begin
                    count_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (count_reg < ldrs_pkg::CNT_W'(ldrs_pkg::QUEUE_DEPTH)))
        begin
            store_reg[count_reg[ldrs_pkg::IDX_W-1:0]] <= cylinder;
        end
        if (cmd.scan && better)
        begin
            best_low_reg <= scan_low;
            best_idx_reg <= scan_idx_reg;
            best_val_reg <= scan_val;
        end
        if (cmd.emit)
        begin
            out_cyl_reg   <= best_val_reg;
            out_dist_reg  <= seek_dist;
            out_total_reg <= sum_next;
            out_last_reg  <= status.pick_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(ldrs_pkg::OUT_W - 2 * ldrs_pkg::CYL_W - ldrs_pkg::TOTAL_W){1'b0}},
                       out_total_reg, out_dist_reg, out_cyl_reg};

endmodule

[hdl/look_disk_request_scheduler_top.sv]
// requests load at one per cycle while no batch is in service; nothing is returned
// until a request with tlast arrives; each result takes one pass over the request store
// (one entry read a cycle), then is registered once the output is free
// rst_n clears the queue and the output; start position and head go back to 53
module look_disk_request_scheduler_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [ldrs_pkg::CYL_W-1:0] cfg_wr_data,   // start_position
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ldrs_pkg::CYL_W-1:0] s_tdata,       // cylinder
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [ldrs_pkg::OUT_W-1:0] m_tdata,       // served_cylinder, seek_distance,
                                                      // total_movement, zero pad
    output logic                       m_tlast
);

    ldrs_pkg::ldrs_cmd_t    cmd;
    ldrs_pkg::ldrs_status_t status;

    ldrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ldrs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cylinder    (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

[tb/ldrs_service_check.sv]
module ldrs_service_check
    import ldrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CYL_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [CYL_W-1:0] s_tdata,
    input  logic             s_tlast,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             m_tlast,
    output int               pending,
    output int               mismatch_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_LSB = 2 * CYL_W;
    localparam int PAD_LSB   = TOTAL_LSB + TOTAL_W;

    typedef struct packed {
        logic [CYL_W-1:0]   cylinder;
        logic [CYL_W-1:0]   seek;
        logic [TOTAL_W-1:0] total;
        logic               fin;
    } service_step_t;

    logic [CYL_W-1:0] start_pos;
    logic [CYL_W-1:0] queued_cyl [QUEUE_DEPTH];
    int               held;
    int               fail_count = 0;
    service_step_t    service_q[$];

    task automatic flag_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // batch completes on the tlast request: sort, sweep down from start, then up
    task automatic take_request(input logic [CYL_W-1:0] cyl, input logic fin);
        logic [CYL_W-1:0] order [QUEUE_DEPTH];
        logic [CYL_W-1:0] visit [QUEUE_DEPTH];
        logic [CYL_W-1:0] key;
        logic [CYL_W-1:0] head;
        logic [CYL_W-1:0] seek_dist;
        logic [19:0]      moved;
        int               n;
        int               split;
        int               i;
        int               j;
        service_step_t    step;
        if (held < QUEUE_DEPTH) begin
            queued_cyl[held] = cyl;
            held++;
        end
        if (!fin)
            return;
        n = held;
        for (i = 0; i < n; i++)
            order[i] = queued_cyl[i];
        for (i = 1; i < n; i++) begin
            key = order[i];
            j = i;
            while (j > 0 && order[j-1] > key) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
        split = n;
        for (i = 0; i < n && split == n; i++)
            if (order[i] > start_pos)
                split = i;
        // downward part nearest first, then the upward part in ascending order
        for (i = 0; i < n; i++)
            visit[i] = (i < split) ? order[split-1-i] : order[i];
        head  = start_pos;
        moved = '0;
        for (i = 0; i < n; i++) begin
            seek_dist = (visit[i] > head) ? visit[i] - head : head - visit[i];
            moved     = moved + 20'(seek_dist);
            step.cylinder = visit[i];
            step.seek     = seek_dist;
            step.total    = moved[TOTAL_W-1:0];
            step.fin      = (i == n - 1);
            service_q.push_back(step);
            head = visit[i];
        end
        held = 0;
    endtask

    task automatic check_result(input logic [OUT_W-1:0] data, input logic fin);
        service_step_t want;
        if (service_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result tdata=%h tlast=%b", data, fin));
            return;
        end
        want = service_q.pop_front();
        if (data[CYL_W-1:0] !== want.cylinder)
            flag_mismatch($sformatf("served cylinder %0d, want %0d",
                                    data[CYL_W-1:0], want.cylinder));
        if (data[TOTAL_LSB-1:CYL_W] !== want.seek)
            flag_mismatch($sformatf("seek distance %0d, want %0d (cylinder %0d)",
                                    data[TOTAL_LSB-1:CYL_W], want.seek, want.cylinder));
        if (data[PAD_LSB-1:TOTAL_LSB] !== want.total)
            flag_mismatch($sformatf("total movement %0d, want %0d (cylinder %0d)",
                                    data[PAD_LSB-1:TOTAL_LSB], want.total, want.cylinder));
        if (data[OUT_W-1:PAD_LSB] !== '0)
            flag_mismatch($sformatf("pad bits %h not zero", data[OUT_W-1:PAD_LSB]));
        if (fin !== want.fin)
            flag_mismatch($sformatf("tlast %b, want %b (cylinder %0d)",
                                    fin, want.fin, want.cylinder));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pos = START_RESET;
            held      = 0;
            service_q.delete();
            pending        <= 0;
            mismatch_total <= fail_count;
        end
        else
        begin
            if (cfg_wr_en)
                start_pos = cfg_wr_data;
            if (m_tvalid && m_tready)
                check_result(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                take_request(s_tdata, s_tlast);
            pending        <= service_q.size();
            mismatch_total <= fail_count;
        end
    end

endmodule

[tb/look_disk_request_scheduler_top_test.sv]
module look_disk_request_scheduler_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ldrs_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    logic             clk;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CYL_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid    = 1'b0;
    logic             s_tready;
    logic [CYL_W-1:0] s_tdata     = '0;
    logic             s_tlast     = 1'b0;
    logic             m_tvalid;
    logic             m_tready    = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    int               pending;
    int               mismatches;
    int               send_gap    = 33;
    int               take_gap    = 54;
    int               sent        = 0;
    int               quiet_cycles = 0;
    logic [CYL_W-1:0] head_cfg    = START_RESET;
    logic [CYL_W-1:0] batch_q[$];

    look_disk_request_scheduler_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    ldrs_service_check service_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .pending        (pending),
        .mismatch_total (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= take_gap);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** look_disk_request_scheduler_top: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // send the queued batch, tlast on its final request
    task automatic send_batch();
        int i;
        for (i = 0; i < batch_q.size(); i++)
        begin
            while ($urandom_range(99) < send_gap)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= batch_q[i];
            s_tlast  <= (i == batch_q.size() - 1);
            do
                @(posedge clk);
            while (!s_tready);
            sent++;
        end
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // only once the batch has drained and the scheduler has settled
    task automatic write_start(input logic [CYL_W-1:0] pos);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= pos;
        head_cfg     = pos;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CYL_W-1:0] pick_cylinder(input logic [CYL_W-1:0] prev);
        logic [CYL_W-1:0] v;
        case ($urandom_range(9))
            0:       v = '0;
            1:       v = '1;
            2:       v = head_cfg;
            3:       v = head_cfg + CYL_W'($urandom_range(4)) - CYL_W'(2);
            4:       v = prev;
            default: v = CYL_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic random_phase(input int quota);
        int               goal;
        int               size;
        int               i;
        logic [CYL_W-1:0] prev;
        goal = sent + quota;
        while (sent < goal)
        begin
            if ($urandom_range(3) == 0)
            begin
                case ($urandom_range(3))
                    0:       write_start('0);
                    1:       write_start('1);
                    2:       write_start(START_RESET);
                    default: write_start(CYL_W'($urandom));
                endcase
            end
            // mostly batches that fit, now and then an overfull one
            size = ($urandom_range(7) == 0) ? $urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4)
                                            : $urandom_range(1, QUEUE_DEPTH);
            batch_q.delete();
            prev = CYL_W'($urandom);
            for (i = 0; i < size; i++)
            begin
                prev = pick_cylinder(prev);
                batch_q.push_back(prev);
            end
            send_batch();
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset start position, requests on both sides of the head
        batch_q = '{16'd98, 16'd183, 16'd37, 16'd122, 16'd14, 16'd124, 16'd65, 16'd67};
        send_batch();
        // lone request right at the head
        batch_q = '{16'd53};
        send_batch();
        // nothing at or below the head
        batch_q = '{16'd100, 16'd60000};
        send_batch();
        // head at the bottom edge
        write_start('0);
        batch_q = '{16'hFFFF, 16'd0};
        send_batch();
        // head at the top edge, nothing above it
        write_start('1);
        batch_q = '{16'd0, 16'hFFFF};
        send_batch();
        // overfull batch, the extra request only ends the batch
        write_start(16'd30000);
        batch_q = '{16'd30001, 16'd29999, 16'd30000, 16'd1, 16'd65534,
                    16'd30000, 16'd12345, 16'd50000, 16'd7};
        send_batch();

        send_gap = 33;
        take_gap = 54;
        random_phase(112);
        send_gap = 54;
        take_gap = 33;
        random_phase(112);
        send_gap = 0;
        take_gap = 0;
        random_phase(112);

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("** look_disk_request_scheduler_top: PASSED **");
        else
            $display("** look_disk_request_scheduler_top: FAILED **");
        $finish;
    end

endmodule
